// ----- hdl/sorted_list_insert_search_top_defines.svh -----
// assertion macros for the sorted list insert/search block
// used by sorted_list_insert_search_top; expects clk_i and rst_ni in scope
`ifndef SORTED_LIST_INSERT_SEARCH_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, inactive during reset
`define SLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive during reset
`define SLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sls_pkg.sv -----
// shared types and constants for the sorted list insert/search block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sls_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 32;
  localparam int unsigned PosW     = 4;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    action_e                action;
    logic signed [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] position;
  } out_item_t;

  // one write and one read address per cycle
  typedef struct packed {
    logic                   we;
    logic [IdxW-1:0]        waddr;
    logic signed [ValW-1:0] wdata;
    logic [IdxW-1:0]        raddr;
  } store_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- hdl/sls_store.sv -----
// value store: Capacity x 32-bit memory, one write and one registered read
// depends on sls_pkg
`timescale 1ns / 1ps
`default_nettype none

module sls_store (
  input  wire logic                          clk_i,
  input  wire sls_pkg::store_req_t           req_i,
  output logic signed [sls_pkg::ValW-1:0]    rdata_o
);

  logic signed [sls_pkg::ValW-1:0] mem [sls_pkg::Capacity];
  logic signed [sls_pkg::ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/sls_cmp.sv -----
// shared signed comparator: key against one stored entry
// depends on sls_pkg
`timescale 1ns / 1ps
`default_nettype none

module sls_cmp (
  input  wire logic signed [sls_pkg::ValW-1:0] key_i,
  input  wire logic signed [sls_pkg::ValW-1:0] entry_i,
  output sls_pkg::cmp_res_t                    res_o
);

  always_comb begin
    res_o.lt = (key_i < entry_i);
    res_o.eq = (key_i == entry_i);
  end

endmodule

`default_nettype wire

// ----- hdl/sorted_list_insert_search_top.sv -----
// sorted list insert/search: sequencer, entry count and result register
// depends on sls_pkg, sls_store, sls_cmp and the block's assertion macros
//
//  channel | signals                          | moves
//  --------+----------------------------------+----------------------------
//  in      | in_valid_i in_ready_o in_data_i  | action and value
//  out     | out_valid_o out_ready_i out_data_o | status and position
//
// each entry visited takes a read state and then a compare state: the single
// read port of the store and the one comparator visit one entry at a time
// inserts scan from the top entry down, moving each larger entry up by one
// searches scan from entry zero up to the first equal entry or the last entry
// reset empties the store at once; a held result does not block the next item
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_insert_search_top_defines.svh"

module sorted_list_insert_search_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sls_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sls_pkg::out_item_t      out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_COMP = 5'b00100,
    S_PUT  = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e                                  state_q, state_d;
  sls_pkg::action_e                        act_q, act_d;
  logic signed [sls_pkg::ValW-1:0]         key_q, key_d;
  logic [sls_pkg::CntW-1:0]                cnt_q, cnt_d;
  logic [sls_pkg::CntW-1:0]                ptr_q, ptr_d;
  sls_pkg::out_item_t                      res_q, res_d;
  sls_pkg::out_item_t                      out_q, out_d;
  logic                                    out_valid_q, out_valid_d;

  sls_pkg::store_req_t                     req;
  logic signed [sls_pkg::ValW-1:0]         rdata;
  sls_pkg::cmp_res_t                       cmp;

  sls_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  sls_cmp u_cmp (
    .key_i   (key_q),
    .entry_i (rdata),
    .res_o   (cmp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    req.we    = 1'b0;
    req.waddr = sls_pkg::IdxW'(ptr_q);
    req.wdata = key_q;
    // inserts look at the entry below the pointer, searches at the pointer
    req.raddr = (act_q == sls_pkg::ACT_INSERT) ?
                sls_pkg::IdxW'(ptr_q - sls_pkg::CntW'(1)) : sls_pkg::IdxW'(ptr_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_data_i.action;
          key_d = in_data_i.value;
          if (in_data_i.action == sls_pkg::ACT_INSERT) begin
            ptr_d = cnt_q;
            if (cnt_q == sls_pkg::CntW'(sls_pkg::Capacity)) begin
              res_d.status   = sls_pkg::ST_FULL;
              res_d.position = '0;
              state_d        = S_RESP;
            end else if (cnt_q == '0) begin
              state_d = S_PUT;
            end else begin
              state_d = S_READ;
            end
          end else begin
            ptr_d = '0;
            if (cnt_q == '0) begin
              res_d.status   = sls_pkg::ST_NOT_FOUND;
              res_d.position = '0;
              state_d        = S_RESP;
            end else begin
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_COMP;
      end
      S_COMP: begin
        if (act_q == sls_pkg::ACT_INSERT) begin
          if (cmp.lt) begin
            // entry is larger than the key: move it up one place
            req.we    = 1'b1;
            req.wdata = rdata;
            ptr_d     = ptr_q - sls_pkg::CntW'(1);
            state_d   = (ptr_q == sls_pkg::CntW'(1)) ? S_PUT : S_READ;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          if (cmp.eq) begin
            res_d.status   = sls_pkg::ST_FOUND;
            res_d.position = sls_pkg::PosW'(ptr_q);
            state_d        = S_RESP;
          end else if ((ptr_q + sls_pkg::CntW'(1)) == cnt_q) begin
            res_d.status   = sls_pkg::ST_NOT_FOUND;
            res_d.position = '0;
            state_d        = S_RESP;
          end else begin
            ptr_d   = ptr_q + sls_pkg::CntW'(1);
            state_d = S_READ;
          end
        end
      end
      S_PUT: begin
        req.we         = 1'b1;
        cnt_d          = cnt_q + sls_pkg::CntW'(1);
        res_d.status   = sls_pkg::ST_INSERTED;
        res_d.position = '0;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    key_q <= key_d;
    ptr_q <= ptr_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  `SLS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= sls_pkg::CntW'(sls_pkg::Capacity), "entry count above capacity")
  `SLS_ASSERT_NOW(a_put_not_full, state_q == S_PUT, cnt_q < sls_pkg::CntW'(sls_pkg::Capacity), "insert write into a full store")
  `SLS_ASSERT_NOW(a_write_state, req.we, state_q == S_COMP || state_q == S_PUT, "store write outside insert states")
  `SLS_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "input ready right after a transfer")

endmodule

`default_nettype wire

// ----- tb/sv/sorted_list_insert_search_top_tb.sv -----
// testbench for sorted_list_insert_search_top: directed and random inserts and searches
// keeps a shadow sorted list to predict each reply; depends on sls_pkg and the block's rtl
`timescale 1ns / 1ps

module sorted_list_insert_search_top_tb;
  import sls_pkg::*;

  localparam int unsigned MaxWait    = 17;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned NumRandom  = 1000;
  localparam int unsigned TailCycles = 2 * Capacity + 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // shadow copy of the sorted list, updated at each input transfer
  logic signed [ValW-1:0] sorted_vals [Capacity];
  int unsigned            sorted_count = 0;
  out_item_t              replies_due [$];

  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  int unsigned recv_hold  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fails = 0;
  int unsigned n_stored = 0, n_rejected = 0, n_hits = 0, n_misses = 0;

  sorted_list_insert_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // applies one insert or search to the shadow list and returns the reply it should give
  function automatic out_item_t apply_to_shadow_list(input in_item_t item);
    out_item_t              reply;
    logic signed [ValW-1:0] key;
    int unsigned            slot;
    int unsigned            idx;
    bit                     hit;
    key            = item.value;
    reply.status   = ST_NOT_FOUND;
    reply.position = '0;
    hit            = 1'b0;
    if (item.action == ACT_INSERT) begin
      if (sorted_count >= Capacity) begin
        reply.status = ST_FULL;
        n_rejected++;
      end else begin
        // new value lands after every entry that is not greater
        slot = sorted_count;
        for (idx = 0; idx < sorted_count; idx++) begin
          if (!hit && key < sorted_vals[idx]) begin
            slot = idx;
            hit  = 1'b1;
          end
        end
        for (idx = sorted_count; idx > slot; idx--) sorted_vals[idx] = sorted_vals[idx - 1];
        sorted_vals[slot] = key;
        sorted_count++;
        reply.status = ST_INSERTED;
        n_stored++;
      end
    end else begin
      for (idx = 0; idx < sorted_count; idx++) begin
        if (!hit && sorted_vals[idx] == key) begin
          hit            = 1'b1;
          reply.status   = ST_FOUND;
          reply.position = idx[PosW-1:0];
        end
      end
      if (hit) n_hits++;
      else n_misses++;
    end
    return reply;
  endfunction

  // half the picks are stored values and their neighbors once the list holds any, some extremes, the rest fully random
  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned            sel;
    logic signed [ValW-1:0] v;
    sel = $urandom_range(0, 9);
    if (sorted_count != 0 && sel < 5) begin
      v = sorted_vals[$urandom_range(0, sorted_count - 1)];
      if (sel == 3) v = v + 1;
      else if (sel == 4) v = v - 1;
    end else if (sel == 5) begin
      case ($urandom_range(0, 3))
        0: v = {1'b1, {(ValW-1){1'b0}}};
        1: v = {1'b0, {(ValW-1){1'b1}}};
        2: v = '0;
        default: v = '1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic send_item(input action_e act, input logic signed [ValW-1:0] val);
    in_item_t    item;
    int unsigned gap;
    item.action = act;
    item.value  = val;
    gap = draw_wait(send_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    replies_due.push_back(apply_to_shadow_list(item));
  endtask

  // sender holds off until every pending reply is back
  task automatic wait_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
  endtask

  task automatic check_reply(input out_item_t got);
    out_item_t want;
    if (replies_due.size() == 0) begin
      $error("reply with nothing pending: status %0d position %0d", got.status, got.position);
      fails++;
    end else begin
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        fails++;
      end
    end
  endtask

  // reply side: check each transfer, then hold ready low for a randomly drawn wait
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_reply(out_data_o);
        recv_hold = draw_wait(recv_burst);
      end else if (recv_hold != 0) begin
        recv_hold = recv_hold - 1;
      end
      out_ready_i <= (recv_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_store();
    send_item(ACT_SEARCH, '0);
    send_item(ACT_SEARCH, {1'b1, {(ValW-1){1'b0}}});
    wait_replies();
  endtask

  task automatic test_extremes_and_duplicates();
    send_burst = 1'b1;
    send_item(ACT_INSERT, {1'b1, {(ValW-1){1'b0}}});
    send_item(ACT_INSERT, {1'b0, {(ValW-1){1'b1}}});
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, '1);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, '0);
    send_burst = 1'b0;
    send_item(ACT_SEARCH, '0);
    send_item(ACT_SEARCH, '1);
    send_item(ACT_SEARCH, {1'b0, {(ValW-1){1'b1}}});
    send_item(ACT_SEARCH, 32'sd1);
    wait_replies();
  endtask

  task automatic test_fill_and_reject();
    while (sorted_count < Capacity) send_item(ACT_INSERT, pick_value());
    send_item(ACT_INSERT, {1'b0, {(ValW-1){1'b1}}});
    send_item(ACT_INSERT, {1'b1, {(ValW-1){1'b0}}});
    send_item(ACT_SEARCH, sorted_vals[Capacity-1]);
    send_item(ACT_SEARCH, sorted_vals[0]);
    wait_replies();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      if (n % 250 == 249) wait_replies();
      send_item(($urandom_range(0, 9) < 4) ? ACT_INSERT : ACT_SEARCH, pick_value());
    end
    send_burst = 1'b0;
    recv_burst = 1'b0;
    wait_replies();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_extremes_and_duplicates();
    test_fill_and_reject();
    test_random_traffic(NumRandom);
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d inserts stored, %0d inserts refused on a full list",
             n_stored, n_rejected);
    $display("covered %0d search hits and %0d search misses", n_hits, n_misses);
    if (fails == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
